// ===== rtl/core/rrsa_pkg.sv =====
// Shared constants and types for the ring rotation source address block.
`timescale 1ns / 1ps

package rrsa_pkg;

  localparam int MAX_DIM = 512;

  localparam int CNT_W   = 10;
  localparam int COORD_W = 9;
  localparam int ADDR_W  = 18;
  localparam int RING_W  = 8;
  localparam int ROT_W   = 30;
  localparam int LEN_W   = 11;
  localparam int SUM_W   = ROT_W + 1;

  localparam int MOD_BITS   = 4;
  localparam int MOD_STAGES = (SUM_W + MOD_BITS - 1) / MOD_BITS;
  localparam int MOD_PAD_W  = MOD_STAGES * MOD_BITS;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_ROT_STEPS = 2'd2
  } cfg_reg_t;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST = CNT_W'(2);
  localparam logic [CNT_W-1:0] COL_COUNT_RST = CNT_W'(2);
  localparam logic [ROT_W-1:0] ROT_STEPS_RST = '0;

endpackage

// ===== rtl/core/rrsa_if.sv =====
// Channel interfaces: request, response and register write.
`timescale 1ns / 1ps

interface rrsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [rrsa_pkg::COORD_W-1:0] dest_row;
  logic [rrsa_pkg::COORD_W-1:0] dest_col;

  modport source (output valid, output dest_row, output dest_col, input ready);
  modport sink (input valid, input dest_row, input dest_col, output ready);
endinterface

interface rrsa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rrsa_pkg::COORD_W-1:0] src_row;
  logic [rrsa_pkg::COORD_W-1:0] src_col;
  logic [rrsa_pkg::ADDR_W-1:0]  src_addr;
  logic [rrsa_pkg::RING_W-1:0]  ring_index;
  logic                         bad_request;

  modport source (output valid, output src_row, output src_col, output src_addr,
                  output ring_index, output bad_request, input ready);
  modport sink (input valid, input src_row, input src_col, input src_addr,
                input ring_index, input bad_request, output ready);
endinterface

interface rrsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrsa_pkg::CFG_IDX_W-1:0] index;
  logic [rrsa_pkg::ROT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ring_rotation_source_address_top.sv =====
// Ring rotation source address generator, pipelined.
//
// One request transfer per cycle, one response per request. The ring-length
// modulo is a restoring remainder spread over 8 stages of 4 bits each;
// together with ring finding, position, sum, back-mapping and address
// multiply stages this sets the depth. A response stalled on rsp.ready holds
// the whole pipeline. Registers are written through cfg (always ready) and
// must only change while the pipeline is empty.
`timescale 1ns / 1ps

module ring_rotation_source_address_top (
  input  logic         clk,
  input  logic         rst,
  rrsa_req_if.sink     req,
  rrsa_rsp_if.source   rsp,
  rrsa_cfg_if.sink     cfg
);

  typedef struct packed {
    logic [rrsa_pkg::LEN_W-1:0]     rem;
    logic [rrsa_pkg::MOD_PAD_W-1:0] x;
    logic [rrsa_pkg::LEN_W-1:0]     len;
    logic [rrsa_pkg::CNT_W-1:0]     h;
    logic [rrsa_pkg::CNT_W-1:0]     w;
    logic [rrsa_pkg::RING_W-1:0]    ring;
    logic                           bad;
  } mod_t;

  logic [rrsa_pkg::CNT_W-1:0] row_count;
  logic [rrsa_pkg::CNT_W-1:0] col_count;
  logic [rrsa_pkg::ROT_W-1:0] rotation_steps;

  logic adv;

  // stage valids
  logic v1, v2, v3, v4, o_vld;
  logic [rrsa_pkg::MOD_STAGES-1:0] mod_vld;

  // stage 1: ring
  logic [rrsa_pkg::COORD_W-1:0] d1_r, d1_c;
  logic [rrsa_pkg::RING_W-1:0]  d1_ring;
  logic                         d1_bad;
  logic [rrsa_pkg::RING_W-1:0]  d1_ring_next;
  logic                         d1_bad_next;

  // stage 2: position on ring
  logic [rrsa_pkg::LEN_W-1:0]  d2_pos, d2_len;
  logic [rrsa_pkg::CNT_W-1:0]  d2_h, d2_w;
  logic [rrsa_pkg::RING_W-1:0] d2_ring;
  logic                        d2_bad;
  logic [rrsa_pkg::LEN_W-1:0]  d2_pos_next, d2_len_next;
  logic [rrsa_pkg::CNT_W-1:0]  d2_h_next, d2_w_next;

  // stage 3: rotated position before modulo
  logic [rrsa_pkg::SUM_W-1:0]  d3_sum;
  logic [rrsa_pkg::LEN_W-1:0]  d3_len;
  logic [rrsa_pkg::CNT_W-1:0]  d3_h, d3_w;
  logic [rrsa_pkg::RING_W-1:0] d3_ring;
  logic                        d3_bad;

  // modulo stages
  mod_t mod_in   [rrsa_pkg::MOD_STAGES];
  mod_t mod_next [rrsa_pkg::MOD_STAGES];
  mod_t mod_q    [rrsa_pkg::MOD_STAGES];

  // stage 4: source coordinate
  logic [rrsa_pkg::COORD_W-1:0] d4_sr, d4_sc;
  logic [rrsa_pkg::RING_W-1:0]  d4_ring;
  logic                         d4_bad;
  logic [rrsa_pkg::COORD_W-1:0] d4_sr_next, d4_sc_next;

  // output stage
  logic [rrsa_pkg::COORD_W-1:0]         o_row, o_col;
  logic [rrsa_pkg::ADDR_W-1:0]          o_addr;
  logic [rrsa_pkg::RING_W-1:0]          o_ring;
  logic                                 o_bad;
  logic [rrsa_pkg::COORD_W+rrsa_pkg::CNT_W-1:0] addr_full;

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= rrsa_pkg::ROW_COUNT_RST;
      col_count      <= rrsa_pkg::COL_COUNT_RST;
      rotation_steps <= rrsa_pkg::ROT_STEPS_RST;
    end else if (cfg.valid) begin
      case (rrsa_pkg::cfg_reg_t'(cfg.index))
        rrsa_pkg::REG_ROW_COUNT: row_count <= cfg.data[rrsa_pkg::CNT_W-1:0];
        rrsa_pkg::REG_COL_COUNT: col_count <= cfg.data[rrsa_pkg::CNT_W-1:0];
        rrsa_pkg::REG_ROT_STEPS: rotation_steps <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  assign adv       = !o_vld || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      mod_vld <= '0;
      v4      <= 1'b0;
      o_vld   <= 1'b0;
    end else if (adv) begin
      v1      <= req.valid;
      v2      <= v1;
      v3      <= v2;
      mod_vld <= {mod_vld[rrsa_pkg::MOD_STAGES-2:0], v3};
      v4      <= mod_vld[rrsa_pkg::MOD_STAGES-1];
      o_vld   <= v4;
    end
  end

  // ---------------- stage 1 ----------------
  always_comb begin
    logic [rrsa_pkg::CNT_W-1:0] r_ext, c_ext, rb, cb, min_rc, min_bb, min_dim, ring_full;
    logic                       shape_bad, coord_bad;
    r_ext     = {1'b0, req.dest_row};
    c_ext     = {1'b0, req.dest_col};
    min_dim   = (row_count < col_count) ? row_count : col_count;
    shape_bad = (row_count < rrsa_pkg::CNT_W'(2)) || (col_count < rrsa_pkg::CNT_W'(2)) ||
                (row_count > rrsa_pkg::CNT_W'(rrsa_pkg::MAX_DIM)) ||
                (col_count > rrsa_pkg::CNT_W'(rrsa_pkg::MAX_DIM)) || min_dim[0];
    coord_bad = (r_ext >= row_count) || (c_ext >= col_count);
    rb        = row_count - rrsa_pkg::CNT_W'(1) - r_ext;
    cb        = col_count - rrsa_pkg::CNT_W'(1) - c_ext;
    min_rc    = (r_ext < c_ext) ? r_ext : c_ext;
    min_bb    = (rb < cb) ? rb : cb;
    ring_full = (min_rc < min_bb) ? min_rc : min_bb;
    d1_ring_next = ring_full[rrsa_pkg::RING_W-1:0];
    d1_bad_next  = shape_bad || coord_bad;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r    <= req.dest_row;
      d1_c    <= req.dest_col;
      d1_ring <= d1_ring_next;
      d1_bad  <= d1_bad_next;
    end
  end

  // ---------------- stage 2 ----------------
  always_comb begin
    logic [rrsa_pkg::COORD_W-1:0] rr, rc;
    logic [rrsa_pkg::CNT_W-1:0]   two_ring;
    logic [rrsa_pkg::LEN_W-1:0]   rr_l, rc_l, h_l, w_l;
    rr        = d1_r - rrsa_pkg::COORD_W'(d1_ring);
    rc        = d1_c - rrsa_pkg::COORD_W'(d1_ring);
    two_ring  = {1'b0, d1_ring, 1'b0};
    d2_h_next = row_count - two_ring;
    d2_w_next = col_count - two_ring;
    rr_l      = rrsa_pkg::LEN_W'(rr);
    rc_l      = rrsa_pkg::LEN_W'(rc);
    h_l       = rrsa_pkg::LEN_W'(d2_h_next);
    w_l       = rrsa_pkg::LEN_W'(d2_w_next);
    d2_len_next = {d2_h_next, 1'b0} + {d2_w_next, 1'b0} - rrsa_pkg::LEN_W'(4);
    if (rr == '0) begin
      d2_pos_next = rc_l;
    end else if (rc_l == w_l - rrsa_pkg::LEN_W'(1)) begin
      d2_pos_next = rr_l + w_l - rrsa_pkg::LEN_W'(1);
    end else if (rr_l == h_l - rrsa_pkg::LEN_W'(1)) begin
      d2_pos_next = d2_len_next - h_l - rc_l + rrsa_pkg::LEN_W'(1);
    end else begin
      d2_pos_next = d2_len_next - rr_l;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_pos  <= d2_pos_next;
      d2_len  <= d2_len_next;
      d2_h    <= d2_h_next;
      d2_w    <= d2_w_next;
      d2_ring <= d1_ring;
      d2_bad  <= d1_bad;
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      d3_sum  <= rrsa_pkg::SUM_W'(d2_pos) + rrsa_pkg::SUM_W'(rotation_steps);
      d3_len  <= d2_len;
      d3_h    <= d2_h;
      d3_w    <= d2_w;
      d3_ring <= d2_ring;
      d3_bad  <= d2_bad;
    end
  end

  // ---------------- modulo by ring length ----------------
  always_comb begin
    mod_in[0].rem  = '0;
    mod_in[0].x    = rrsa_pkg::MOD_PAD_W'(d3_sum);
    mod_in[0].len  = d3_len;
    mod_in[0].h    = d3_h;
    mod_in[0].w    = d3_w;
    mod_in[0].ring = d3_ring;
    mod_in[0].bad  = d3_bad;
  end

  for (genvar k = 1; k < rrsa_pkg::MOD_STAGES; k++) begin : g_mod_link
    assign mod_in[k] = mod_q[k-1];
  end

  for (genvar k = 0; k < rrsa_pkg::MOD_STAGES; k++) begin : g_mod
    always_comb begin
      logic [rrsa_pkg::LEN_W:0]       t;
      logic [rrsa_pkg::LEN_W-1:0]     rem;
      logic [rrsa_pkg::MOD_PAD_W-1:0] x;
      rem = mod_in[k].rem;
      x   = mod_in[k].x;
      for (int j = 0; j < rrsa_pkg::MOD_BITS; j++) begin
        t = {rem, x[rrsa_pkg::MOD_PAD_W-1]};
        if (t >= {1'b0, mod_in[k].len}) begin
          t = t - {1'b0, mod_in[k].len};
        end
        rem = t[rrsa_pkg::LEN_W-1:0];
        x   = {x[rrsa_pkg::MOD_PAD_W-2:0], 1'b0};
      end
      mod_next[k]     = mod_in[k];
      mod_next[k].rem = rem;
      mod_next[k].x   = x;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mod_q[k] <= mod_next[k];
      end
    end
  end

  // ---------------- stage 4: back to coordinates ----------------
  always_comb begin
    mod_t                       mf;
    logic [rrsa_pkg::LEN_W-1:0] hs, ws, pos, sr, sc;
    mf  = mod_q[rrsa_pkg::MOD_STAGES-1];
    pos = mf.rem;
    hs  = rrsa_pkg::LEN_W'(mf.h) - rrsa_pkg::LEN_W'(1);
    ws  = rrsa_pkg::LEN_W'(mf.w) - rrsa_pkg::LEN_W'(1);
    if (pos < ws) begin
      sr = '0;
      sc = pos;
    end else if (pos < ws + hs) begin
      sr = pos - ws;
      sc = ws;
    end else if (pos < {ws[rrsa_pkg::LEN_W-2:0], 1'b0} + hs) begin
      sr = hs;
      sc = {ws[rrsa_pkg::LEN_W-2:0], 1'b0} + hs - pos;
    end else begin
      sr = {ws[rrsa_pkg::LEN_W-2:0], 1'b0} + {hs[rrsa_pkg::LEN_W-2:0], 1'b0} - pos;
      sc = '0;
    end
    sr = sr + rrsa_pkg::LEN_W'(mf.ring);
    sc = sc + rrsa_pkg::LEN_W'(mf.ring);
    d4_sr_next = sr[rrsa_pkg::COORD_W-1:0];
    d4_sc_next = sc[rrsa_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_sr   <= d4_sr_next;
      d4_sc   <= d4_sc_next;
      d4_ring <= mod_q[rrsa_pkg::MOD_STAGES-1].ring;
      d4_bad  <= mod_q[rrsa_pkg::MOD_STAGES-1].bad;
    end
  end

  // ---------------- output stage ----------------
  assign addr_full = d4_sr * col_count + (rrsa_pkg::COORD_W + rrsa_pkg::CNT_W)'(d4_sc);

  always_ff @(posedge clk) begin
    if (adv) begin
      o_bad  <= d4_bad;
      o_row  <= d4_bad ? '0 : d4_sr;
      o_col  <= d4_bad ? '0 : d4_sc;
      o_ring <= d4_bad ? '0 : d4_ring;
      o_addr <= d4_bad ? '0 : addr_full[rrsa_pkg::ADDR_W-1:0];
    end
  end

  assign rsp.valid       = o_vld;
  assign rsp.src_row     = o_row;
  assign rsp.src_col     = o_col;
  assign rsp.src_addr    = o_addr;
  assign rsp.ring_index  = o_ring;
  assign rsp.bad_request = o_bad;

  // ---------------- assertions ----------------
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("response valid right after reset");

  a_src_in_shape: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.bad_request |->
      ({1'b0, rsp.src_row} < row_count) && ({1'b0, rsp.src_col} < col_count))
    else $error("source coordinate outside the matrix");

  a_ring_in_shape: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.bad_request |->
      ({1'b0, rsp.ring_index, 1'b0} < row_count) &&
      ({1'b0, rsp.ring_index, 1'b0} < col_count))
    else $error("ring index beyond the innermost ring");

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    mod_vld[rrsa_pkg::MOD_STAGES-1] && !mod_q[rrsa_pkg::MOD_STAGES-1].bad |->
      mod_q[rrsa_pkg::MOD_STAGES-1].rem < mod_q[rrsa_pkg::MOD_STAGES-1].len)
    else $error("ring position not reduced below ring length");

endmodule
